/* rtl/lruc_pkg.sv */
package lruc_pkg;

   localparam int KEY_W   = 64;
   localparam int WORD_W  = 64;
   localparam int STAMP_W = 32;
   localparam int WIDX_W  = 3;
   localparam int STAT_W  = 2;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_MISS = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_HIT  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_PUT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_CLAIM,
      ST_WRITE,
      ST_RD_ISSUE,
      ST_RD_SEND
   } state_type;

   // Broadcast from the controller to every tag cell; only the selected cell acts.
   typedef struct packed {
      logic               claim;
      logic               touch;
      logic [STAMP_W-1:0] stamp;
      logic [KEY_W-1:0]   node;
      logic [KEY_W-1:0]   block;
   } cell_ctl_type;

endpackage

/* rtl/lruc_cell.sv */
module lruc_cell #(
   parameter int CELL_INDEX = 0,
   parameter int SW         = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sel,
   input  lruc_pkg::cell_ctl_type        ctl,
   output logic                          hit,
   output logic                          valid,
   input  logic [lruc_pkg::STAMP_W-1:0]  chain_stamp_in,
   input  logic [SW-1:0]                 chain_idx_in,
   output logic [lruc_pkg::STAMP_W-1:0]  chain_stamp_out,
   output logic [SW-1:0]                 chain_idx_out
);

   logic                          valid_ff;
   logic [lruc_pkg::KEY_W-1:0]    node_ff;
   logic [lruc_pkg::KEY_W-1:0]    block_ff;
   logic [lruc_pkg::STAMP_W-1:0]  stamp_ff;
   logic [lruc_pkg::STAMP_W-1:0]  chain_stamp_ff;
   logic [SW-1:0]                 chain_idx_ff;
   logic                          take_own;

   assign hit   = valid_ff && (node_ff == ctl.node) && (block_ff == ctl.block);
   assign valid = valid_ff;

   // The head of the chain always takes its own stamp; later cells win only
   // on a strictly smaller stamp, so ties stay with the lower index.
   assign take_own = (CELL_INDEX == 0) || (stamp_ff < chain_stamp_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel && ctl.claim) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && ctl.claim) begin
         node_ff  <= ctl.node;
         block_ff <= ctl.block;
      end
      if (sel && (ctl.claim || ctl.touch)) begin
         stamp_ff <= ctl.stamp;
      end
      if (take_own) begin
         chain_stamp_ff <= stamp_ff;
         chain_idx_ff   <= SW'(CELL_INDEX);
      end else begin
         chain_stamp_ff <= chain_stamp_in;
         chain_idx_ff   <= chain_idx_in;
      end
   end

   assign chain_stamp_out = chain_stamp_ff;
   assign chain_idx_out   = chain_idx_ff;

endmodule

/* rtl/lruc_store.sv */
module lruc_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [lruc_pkg::WORD_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [lruc_pkg::WORD_W-1:0]  rd_data
);

   logic [lruc_pkg::WORD_W-1:0] mem [DEPTH];
   logic [lruc_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fully_assoc_lru_block_cache.sv */
// A get miss presents its status word once the output register is free. A get hit presents
// its block word by word, each a store read, then an output load. The next word is taken only
// when the last one is done: a miss after LOOKUP, a put word after LOOKUP and WRITE, put word 0
// after LOOKUP, CLAIM and WRITE (SCAN first when no entry matches, all are valid and the oldest
// stamp has to travel down the cell chain), a hit after its whole block, later while rsp_stall is high.
// Reset (synchronous, active high) clears all valid bits, the stamp counter, the put
// slot and the control state; the block store is not cleared and needs no sweep.
module fully_assoc_lru_block_cache #(
   parameter int ENTRIES     = 16,
   parameter int BLOCK_WORDS = 8
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [lruc_pkg::KEY_W-1:0]    req_node_id,
   input  logic [lruc_pkg::KEY_W-1:0]    req_block_id,
   input  logic [lruc_pkg::WIDX_W-1:0]   req_word_index,
   input  logic [lruc_pkg::WORD_W-1:0]   req_data_word,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lruc_pkg::STAT_W-1:0]   rsp_status,
   output logic [lruc_pkg::WORD_W-1:0]   rsp_data_word_res,
   output logic [lruc_pkg::WIDX_W-1:0]   rsp_word_index_res,
   output logic                          rsp_last
);

   // Slot index, word counter and store address widths.
   localparam int SW    = $clog2(ENTRIES);
   localparam int WW    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
   localparam int DEPTH = ENTRIES * BLOCK_WORDS;
   localparam int AW    = $clog2(DEPTH);

   // The accepted request word is held here while it is worked on.
   logic                          func_ff;
   logic [lruc_pkg::KEY_W-1:0]    node_ff;
   logic [lruc_pkg::KEY_W-1:0]    block_ff;
   logic [lruc_pkg::WIDX_W-1:0]   widx_ff;
   logic [lruc_pkg::WORD_W-1:0]   data_ff;

   lruc_pkg::state_type           state_ff, state_in;
   logic [SW-1:0]                 slot_ff, slot_in;
   logic [SW-1:0]                 put_slot_ff, put_slot_in;
   logic [WW-1:0]                 cnt_ff, cnt_in;
   logic [SW-1:0]                 scan_cnt_ff, scan_cnt_in;
   logic [lruc_pkg::STAMP_W-1:0]  stamp_ctr_ff, stamp_ctr_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lruc_pkg::STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [lruc_pkg::WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [lruc_pkg::WIDX_W-1:0]   rsp_widx_ff, rsp_widx_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_load;

   // Cell row and the least-recently-used chain that runs through it.
   lruc_pkg::cell_ctl_type        cell_ctl;
   logic [SW-1:0]                 cell_sel_idx;
   logic [ENTRIES-1:0]            hit_vec;
   logic [ENTRIES-1:0]            valid_vec;
   logic [lruc_pkg::STAMP_W-1:0]  chain_stamp [ENTRIES+1];
   logic [SW-1:0]                 chain_idx   [ENTRIES+1];

   logic                          any_hit, any_inv;
   logic [SW-1:0]                 hit_idx, inv_idx;

   // Block store ports.
   logic                          mem_we, mem_re;
   logic [AW-1:0]                 mem_waddr, mem_raddr;
   logic [lruc_pkg::WORD_W-1:0]   mem_rdata;

   logic                          accept;
   logic                          out_free;
   logic                          widx_ok, widx_zero, widx_last, cnt_last, scan_done;

   assign accept   = req_valid && !req_stall;
   // The output register can take a new word when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign widx_ok   = 32'(widx_ff) < BLOCK_WORDS;
   assign widx_zero = (widx_ff == '0);
   assign widx_last = 32'(widx_ff) == (BLOCK_WORDS - 1);
   assign cnt_last  = 32'(cnt_ff) == (BLOCK_WORDS - 1);
   assign scan_done = 32'(scan_cnt_ff) == (ENTRIES - 1);

   // The head cell ignores its chain input, so the seed is a don't-care constant.
   assign chain_stamp[0] = '0;
   assign chain_idx[0]   = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lruc_cell #(
         .CELL_INDEX (g),
         .SW         (SW)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .sel             (cell_sel_idx == SW'(g)),
         .ctl             (cell_ctl),
         .hit             (hit_vec[g]),
         .valid           (valid_vec[g]),
         .chain_stamp_in  (chain_stamp[g]),
         .chain_idx_in    (chain_idx[g]),
         .chain_stamp_out (chain_stamp[g+1]),
         .chain_idx_out   (chain_idx[g+1])
      );
   end

   // Lowest-index matching entry and lowest-index empty entry.
   always_comb begin
      hit_idx = '0;
      inv_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = SW'(i);
         end
         if (!valid_vec[i]) begin
            inv_idx = SW'(i);
         end
      end
   end

   assign any_hit = |hit_vec;
   assign any_inv = ~&valid_vec;

   // Each entry owns BLOCK_WORDS consecutive words of the store.
   assign mem_waddr = AW'(AW'(put_slot_ff) * AW'(BLOCK_WORDS)) + AW'(widx_ff);
   assign mem_raddr = AW'(AW'(slot_ff) * AW'(BLOCK_WORDS)) + AW'(cnt_ff);

   lruc_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (data_ff),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lruc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lruc_pkg::ST_LOOKUP;
            end
         end
         lruc_pkg::ST_LOOKUP: begin
            if (func_ff == lruc_pkg::FUNC_GET) begin
               if (any_hit) begin
                  state_in = lruc_pkg::ST_RD_ISSUE;
               end else if (out_free) begin
                  state_in = lruc_pkg::ST_IDLE;
               end
            end else if (!widx_ok) begin
               state_in = lruc_pkg::ST_IDLE;
            end else if (widx_zero) begin
               state_in = (any_hit || any_inv) ? lruc_pkg::ST_CLAIM : lruc_pkg::ST_SCAN;
            end else begin
               state_in = lruc_pkg::ST_WRITE;
            end
         end
         lruc_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = lruc_pkg::ST_CLAIM;
            end
         end
         lruc_pkg::ST_CLAIM: begin
            state_in = lruc_pkg::ST_WRITE;
         end
         lruc_pkg::ST_WRITE: begin
            if (!widx_last || out_free) begin
               state_in = lruc_pkg::ST_IDLE;
            end
         end
         lruc_pkg::ST_RD_ISSUE: begin
            state_in = lruc_pkg::ST_RD_SEND;
         end
         lruc_pkg::ST_RD_SEND: begin
            if (out_free) begin
               state_in = cnt_last ? lruc_pkg::ST_IDLE : lruc_pkg::ST_RD_ISSUE;
            end
         end
         default: begin
            state_in = lruc_pkg::ST_IDLE;
         end
      endcase
   end

   // Output and datapath control.
   always_comb begin
      req_stall      = 1'b1;
      // Every cell compares the held key in parallel and sees the same update word.
      cell_ctl.node  = node_ff;
      cell_ctl.block = block_ff;
      cell_ctl.stamp = stamp_ctr_ff;
      cell_ctl.claim = 1'b0;
      cell_ctl.touch = 1'b0;
      cell_sel_idx   = slot_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      slot_in        = slot_ff;
      put_slot_in    = put_slot_ff;
      cnt_in         = cnt_ff;
      scan_cnt_in    = scan_cnt_ff;
      stamp_ctr_in   = stamp_ctr_ff;
      rsp_load       = 1'b0;
      rsp_status_in  = lruc_pkg::STATUS_MISS;
      rsp_data_in    = '0;
      rsp_widx_in    = '0;
      rsp_last_in    = 1'b1;
      unique case (state_ff)
         lruc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         lruc_pkg::ST_LOOKUP: begin
            if (func_ff == lruc_pkg::FUNC_GET) begin
               if (any_hit) begin
                  // Refresh the entry's stamp and start streaming its block.
                  cell_sel_idx   = hit_idx;
                  cell_ctl.touch = 1'b1;
                  stamp_ctr_in   = stamp_ctr_ff + 1'b1;
                  slot_in        = hit_idx;
                  cnt_in         = '0;
               end else begin
                  rsp_load = out_free;
               end
            end else if (widx_ok && widx_zero) begin
               if (any_hit) begin
                  slot_in = hit_idx;
               end else if (any_inv) begin
                  slot_in = inv_idx;
               end else begin
                  scan_cnt_in = '0;
               end
            end
         end
         lruc_pkg::ST_SCAN: begin
            // The chain is registered in every cell, so the scan waits until settled stamps reach its tail.
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_done) begin
               slot_in = chain_idx[ENTRIES];
            end
         end
         lruc_pkg::ST_CLAIM: begin
            cell_ctl.claim = 1'b1;
            stamp_ctr_in   = stamp_ctr_ff + 1'b1;
            put_slot_in    = slot_ff;
         end
         lruc_pkg::ST_WRITE: begin
            if (!widx_last) begin
               mem_we = 1'b1;
            end else if (out_free) begin
               mem_we        = 1'b1;
               rsp_load      = 1'b1;
               rsp_status_in = lruc_pkg::STATUS_PUT;
            end
         end
         lruc_pkg::ST_RD_ISSUE: begin
            mem_re = 1'b1;
         end
         lruc_pkg::ST_RD_SEND: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = lruc_pkg::STATUS_HIT;
               rsp_data_in   = mem_rdata;
               rsp_widx_in   = lruc_pkg::WIDX_W'(cnt_ff);
               rsp_last_in   = cnt_last;
               cnt_in        = cnt_ff + 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lruc_pkg::ST_IDLE;
         put_slot_ff  <= '0;
         stamp_ctr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         put_slot_ff  <= put_slot_in;
         stamp_ctr_ff <= stamp_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         node_ff  <= req_node_id;
         block_ff <= req_block_id;
         widx_ff  <= req_word_index;
         data_ff  <= req_data_word;
      end
      slot_ff     <= slot_in;
      cnt_ff      <= cnt_in;
      scan_cnt_ff <= scan_cnt_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_widx_ff   <= rsp_widx_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_data_word_res  = rsp_data_ff;
   assign rsp_word_index_res = rsp_widx_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
